FILE: sv/fixed_point_alu_16_32_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU
// Concurrent check wrappers; they compile to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_16_32_DEFINES_SVH
`define FIXED_POINT_ALU_16_32_DEFINES_SVH
`ifndef SYNTH
// check a property while out of reset
`define FPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fpa check failed");
// check a property at every edge, reset included
`define FPA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("fpa reset check failed");
`else
`define FPA_ASSERT(lbl, clk, rst_n, prop)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/fpa_pkg.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, widths and the word that travels down the divide pipeline.
// ---------------------------------------------------------------------------
package fpa_pkg;
    localparam int OpW   = 4;
    localparam int DataW = 32;
    localparam int HalfW = 16;
    localparam int DivSteps = 32;

    localparam logic [OpW-1:0] OP_ADD16 = 4'd0;
    localparam logic [OpW-1:0] OP_ADD32 = 4'd1;
    localparam logic [OpW-1:0] OP_SUB16 = 4'd2;
    localparam logic [OpW-1:0] OP_SUB32 = 4'd3;
    localparam logic [OpW-1:0] OP_NEG16 = 4'd4;
    localparam logic [OpW-1:0] OP_NEG32 = 4'd5;
    localparam logic [OpW-1:0] OP_MULLO = 4'd6;
    localparam logic [OpW-1:0] OP_MULHI = 4'd7;
    localparam logic [OpW-1:0] OP_DIV16 = 4'd8;
    localparam logic [OpW-1:0] OP_DIV32 = 4'd9;

    localparam logic [HalfW-1:0] MinNeg16 = 16'h8000;
    localparam logic [DataW-1:0] MinNeg32 = 32'h8000_0000;

    typedef struct packed {
        logic             valid;
        logic [OpW-1:0]   op;
        logic [DataW-1:0] res;    // result of the non-divide ops
        logic             carry;
        logic             ovf;
        logic             err;    // zero divisor
        logic             neg;    // quotient sign
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dq;     // dividend bits out, quotient bits in
        logic [DataW-1:0] dvs;
    } t_div;
endpackage

FILE: sv/fpa_div_step.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU divide step
// One restoring-division bit per stage, registered, with payload alongside.
// ---------------------------------------------------------------------------
module fpa_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fpa_pkg::t_div i_word,
    output fpa_pkg::t_div o_word
);
    import fpa_pkg::*;

    t_div             r_word;
    t_div             n_word;
    logic [DataW:0]   w_trial;

    always_comb begin
        w_trial = {i_word.rem, i_word.dq[DataW-1]} - {1'b0, i_word.dvs};
        n_word = i_word;
        if (w_trial[DataW]) begin
            // restore: keep the shifted remainder
            n_word.rem = {i_word.rem[DataW-2:0], i_word.dq[DataW-1]};
        end else begin
            n_word.rem = w_trial[DataW-1:0];
        end
        n_word.dq = {i_word.dq[DataW-2:0], ~w_trial[DataW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word.valid <= n_word.valid;
        end
        if (i_en) begin
            r_word.op    <= n_word.op;
            r_word.res   <= n_word.res;
            r_word.carry <= n_word.carry;
            r_word.ovf   <= n_word.ovf;
            r_word.err   <= n_word.err;
            r_word.neg   <= n_word.neg;
            r_word.rem   <= n_word.rem;
            r_word.dq    <= n_word.dq;
            r_word.dvs   <= n_word.dvs;
        end
    end

    assign o_word = r_word;
endmodule

FILE: sv/fixed_point_alu_16_32.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU, 16 and 32 bit
// Add, subtract, negate, 16x16 multiply and signed divide with flags.
// ---------------------------------------------------------------------------
// The ALU takes one command word per cycle while o_stall is low and returns
// one result word per command, in order. Every command runs through the same
// 35-register path: an input register, a decode stage that does add,
// subtract, negate and multiply and prepares the divide operands, 32
// restoring-divide stages (one quotient bit each) and an output register.
// Throughput is one word per cycle while the output is not stalled. When the
// output word is stalled the whole pipe holds and o_stall goes high, so
// nothing is lost or repeated. Unused opcodes return zero, all flags clear.
module fixed_point_alu_16_32 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [fpa_pkg::OpW-1:0]     i_opcode,
    input  logic [fpa_pkg::DataW-1:0]   i_operand_a,
    input  logic [fpa_pkg::DataW-1:0]   i_operand_b,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fpa_pkg::DataW-1:0]   o_result_word,
    output logic                        o_carry_flag,
    output logic                        o_overflow_flag,
    output logic                        o_error_flag
);
    import fpa_pkg::*;
`include "fixed_point_alu_16_32_defines.svh"

    // global advance: hold everything while the output word is stalled
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // input register
    logic             r_s0_valid;
    logic [OpW-1:0]   r_s0_op;
    logic [DataW-1:0] r_s0_a;
    logic [DataW-1:0] r_s0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
        end
        if (w_adv) begin
            r_s0_op <= i_opcode;
            r_s0_a  <= i_operand_a;
            r_s0_b  <= i_operand_b;
        end
    end

    // decode stage: direct ops and divide setup
    logic [HalfW-1:0]   w_a16, w_b16;
    logic [HalfW:0]     w_sum16, w_dif16;
    logic [DataW:0]     w_sum32, w_dif32;
    logic [DataW-1:0]   w_prod;
    logic [HalfW-1:0]   w_ua16, w_ub16;
    logic [DataW-1:0]   w_ua32, w_ub32;
    t_div               n_s1;
    t_div               r_s1;

    always_comb begin
        w_a16   = r_s0_a[HalfW-1:0];
        w_b16   = r_s0_b[HalfW-1:0];
        w_sum16 = {1'b0, w_a16} + {1'b0, w_b16};
        w_dif16 = {1'b0, w_a16} - {1'b0, w_b16};
        w_sum32 = {1'b0, r_s0_a} + {1'b0, r_s0_b};
        w_dif32 = {1'b0, r_s0_a} - {1'b0, r_s0_b};
        w_prod  = w_a16 * w_b16;
        w_ua16  = w_a16[HalfW-1] ? -w_a16 : w_a16;
        w_ub16  = w_b16[HalfW-1] ? -w_b16 : w_b16;
        w_ua32  = r_s0_a[DataW-1] ? -r_s0_a : r_s0_a;
        w_ub32  = r_s0_b[DataW-1] ? -r_s0_b : r_s0_b;

        n_s1       = '0;
        n_s1.valid = r_s0_valid;
        n_s1.op    = r_s0_op;
        case (r_s0_op)
            OP_ADD16: begin
                n_s1.res   = {{HalfW{1'b0}}, w_sum16[HalfW-1:0]};
                n_s1.carry = w_sum16[HalfW];
                n_s1.ovf   = ~(w_a16[HalfW-1] ^ w_b16[HalfW-1])
                             & (w_a16[HalfW-1] ^ w_sum16[HalfW-1]);
            end
            OP_ADD32: begin
                n_s1.res   = w_sum32[DataW-1:0];
                n_s1.carry = w_sum32[DataW];
                n_s1.ovf   = ~(r_s0_a[DataW-1] ^ r_s0_b[DataW-1])
                             & (r_s0_a[DataW-1] ^ w_sum32[DataW-1]);
            end
            OP_SUB16: begin
                n_s1.res   = {{HalfW{1'b0}}, w_dif16[HalfW-1:0]};
                // minuend at the most negative value also flags a borrow
                n_s1.carry = w_dif16[HalfW] || (w_a16 == MinNeg16);
                n_s1.ovf   = (w_a16[HalfW-1] ^ w_b16[HalfW-1])
                             & (w_a16[HalfW-1] ^ w_dif16[HalfW-1]);
            end
            OP_SUB32: begin
                n_s1.res   = w_dif32[DataW-1:0];
                n_s1.carry = w_dif32[DataW];
                n_s1.ovf   = (r_s0_a[DataW-1] ^ r_s0_b[DataW-1])
                             & (r_s0_a[DataW-1] ^ w_dif32[DataW-1]);
            end
            OP_NEG16: begin
                // most negative value negates to itself
                n_s1.res = {{HalfW{1'b0}}, -w_a16};
                n_s1.ovf = (w_a16 == MinNeg16);
            end
            OP_NEG32: begin
                n_s1.res = -r_s0_a;
                n_s1.ovf = (r_s0_a == MinNeg32);
            end
            OP_MULLO, OP_MULHI: begin
                if (w_a16 == MinNeg16 || w_b16 == MinNeg16) begin
                    n_s1.res = {{HalfW{1'b0}}, MinNeg16};
                    n_s1.ovf = 1'b1;
                end else if (r_s0_op == OP_MULLO) begin
                    n_s1.res = {{HalfW{1'b0}}, w_prod[HalfW-1:0]};
                    n_s1.ovf = (w_prod[DataW-1:HalfW] != '0);
                end else begin
                    n_s1.res = {{HalfW{1'b0}}, w_prod[DataW-1:HalfW]};
                end
            end
            OP_DIV16: begin
                n_s1.err = (w_b16 == '0);
                n_s1.neg = w_a16[HalfW-1] ^ w_b16[HalfW-1];
                n_s1.dq  = {{HalfW{1'b0}}, w_ua16};
                n_s1.dvs = {{HalfW{1'b0}}, w_ub16};
            end
            OP_DIV32: begin
                n_s1.err = (r_s0_b == '0);
                n_s1.neg = r_s0_a[DataW-1] ^ r_s0_b[DataW-1];
                n_s1.dq  = w_ua32;
                n_s1.dvs = w_ub32;
            end
            default: begin
                n_s1.res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_adv) begin
            r_s1.valid <= n_s1.valid;
        end
        if (w_adv) begin
            r_s1.op    <= n_s1.op;
            r_s1.res   <= n_s1.res;
            r_s1.carry <= n_s1.carry;
            r_s1.ovf   <= n_s1.ovf;
            r_s1.err   <= n_s1.err;
            r_s1.neg   <= n_s1.neg;
            r_s1.rem   <= n_s1.rem;
            r_s1.dq    <= n_s1.dq;
            r_s1.dvs   <= n_s1.dvs;
        end
    end

    // divide pipe: one quotient bit per stage
    t_div w_div [0:DivSteps];
    assign w_div[0] = r_s1;

    for (genvar g = 0; g < DivSteps; g++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_word  (w_div[g]),
            .o_word  (w_div[g+1])
        );
    end

    // finish: sign the quotient, pick the result
    t_div             w_last;
    logic [DataW-1:0] w_quo;
    logic [DataW-1:0] n_res;
    logic             n_carry, n_ovf, n_err;

    always_comb begin
        w_last  = w_div[DivSteps];
        w_quo   = w_last.neg ? -w_last.dq : w_last.dq;
        n_res   = w_last.res;
        n_carry = w_last.carry;
        n_ovf   = w_last.ovf;
        n_err   = 1'b0;
        case (w_last.op)
            OP_DIV16, OP_DIV32: begin
                n_carry = 1'b0;
                n_ovf   = 1'b0;
                n_err   = w_last.err;
                if (w_last.err) begin
                    n_res = '0;
                end else if (w_last.op == OP_DIV16) begin
                    n_res = {{HalfW{1'b0}}, w_quo[HalfW-1:0]};
                end else begin
                    n_res = w_quo;
                end
            end
            default: begin
                n_err = 1'b0;
            end
        endcase
    end

    // output register
    logic             r_out_valid;
    logic [OpW-1:0]   r_out_op;
    logic [DataW-1:0] r_out_res;
    logic             r_out_carry, r_out_ovf, r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.valid;
        end
        if (w_adv) begin
            r_out_op    <= w_last.op;
            r_out_res   <= n_res;
            r_out_carry <= n_carry;
            r_out_ovf   <= n_ovf;
            r_out_err   <= n_err;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_word   = r_out_res;
    assign o_carry_flag    = r_out_carry;
    assign o_overflow_flag = r_out_ovf;
    assign o_error_flag    = r_out_err;

    `FPA_ASSERT(a_err_clean, i_clk, i_rst_n, (o_valid && o_error_flag) |-> (o_result_word == '0 && !o_carry_flag && !o_overflow_flag))
    `FPA_ASSERT(a_carry_op, i_clk, i_rst_n, (o_valid && o_carry_flag) |-> (r_out_op == OP_ADD16 || r_out_op == OP_ADD32 || r_out_op == OP_SUB16 || r_out_op == OP_SUB32))
    `FPA_ASSERT(a_err_op, i_clk, i_rst_n, (o_valid && o_error_flag) |-> (r_out_op == OP_DIV16 || r_out_op == OP_DIV32))
    `FPA_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_valid)
endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives random and corner commands through the ALU under varied idling and
// checks every result word and flag against an in-bench prediction.
// ---------------------------------------------------------------------------
module testbench;
    import fpa_pkg::*;

    typedef struct {
        logic [OpW-1:0]   op;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } t_cmd;

    typedef struct {
        logic [DataW-1:0] res;
        logic             carry;
        logic             ovf;
        logic             err;
    } t_alu_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic [OpW-1:0]   i_opcode = '0;
    logic [DataW-1:0] i_operand_a = '0;
    logic [DataW-1:0] i_operand_b = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [DataW-1:0] o_result_word;
    logic             o_carry_flag;
    logic             o_overflow_flag;
    logic             o_error_flag;

    fixed_point_alu_16_32 DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_cmd     cmd_queue[$];
    t_alu_res expected_results[$];
    int       idle_pct = 0;
    int       stall_pct = 0;
    bit       hold_off = 1'b0;
    bit       stim_done = 1'b0;
    int       errors = 0;
    int       quiet_cycles = 0;

    // Signed truncating divide at 16 or 32 bits, operands already masked.
    function automatic logic [DataW-1:0] signed_quotient(logic [DataW-1:0] a,
                                                          logic [DataW-1:0] b,
                                                          bit wide);
        logic [DataW-1:0] sign_bit;
        logic [DataW-1:0] mask;
        logic [DataW-1:0] ua;
        logic [DataW-1:0] ub;
        logic [DataW-1:0] q;
        bit               na;
        bit               nb;
        sign_bit = wide ? MinNeg32 : {16'h0, MinNeg16};
        mask = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        na = (a & sign_bit) != 0;
        nb = (b & sign_bit) != 0;
        ua = na ? ((0 - a) & mask) : a;
        ub = nb ? ((0 - b) & mask) : b;
        q = ua / ub;
        if (na != nb) q = 0 - q;
        return q & mask;
    endfunction

    function automatic t_alu_res alu_predict(t_cmd c);
        t_alu_res         r;
        logic [15:0]      a16;
        logic [15:0]      b16;
        logic [16:0]      s17;
        logic [15:0]      r16;
        logic [32:0]      s33;
        logic [31:0]      p;
        a16 = c.a[15:0];
        b16 = c.b[15:0];
        r = '{default: '0};
        case (c.op)
            OP_ADD16: begin
                s17 = a16 + b16;
                r16 = s17[15:0];
                r.res = {16'h0, r16};
                r.carry = s17[16];
                r.ovf = (a16[15] == b16[15]) && (r16[15] != a16[15]);
            end
            OP_ADD32: begin
                s33 = c.a + c.b;
                r.res = s33[31:0];
                r.carry = s33[32];
                r.ovf = (c.a[31] == c.b[31]) && (r.res[31] != c.a[31]);
            end
            OP_SUB16: begin
                r16 = a16 - b16;
                r.res = {16'h0, r16};
                r.carry = (a16 == MinNeg16) || (a16 < b16);
                r.ovf = (a16[15] != b16[15]) && (r16[15] != a16[15]);
            end
            OP_SUB32: begin
                r.res = c.a - c.b;
                r.carry = c.a < c.b;
                r.ovf = (c.a[31] != c.b[31]) && (r.res[31] != c.a[31]);
            end
            OP_NEG16: begin
                if (a16 == MinNeg16) begin
                    r.res = {16'h0, MinNeg16};
                    r.ovf = 1'b1;
                end else begin
                    r16 = 16'h0 - a16;
                    r.res = {16'h0, r16};
                end
            end
            OP_NEG32: begin
                if (c.a == MinNeg32) begin
                    r.res = MinNeg32;
                    r.ovf = 1'b1;
                end else begin
                    r.res = 0 - c.a;
                end
            end
            OP_MULLO, OP_MULHI: begin
                if (a16 == MinNeg16 || b16 == MinNeg16) begin
                    r.res = {16'h0, MinNeg16};
                    r.ovf = 1'b1;
                end else begin
                    p = a16 * b16;
                    if (c.op == OP_MULLO) begin
                        r.res = {16'h0, p[15:0]};
                        r.ovf = p[31:16] != 0;
                    end else begin
                        r.res = {16'h0, p[31:16]};
                    end
                end
            end
            OP_DIV16: begin
                if (b16 == 0) r.err = 1'b1;
                else r.res = signed_quotient({16'h0, a16}, {16'h0, b16}, 1'b0);
            end
            OP_DIV32: begin
                if (c.b == 0) r.err = 1'b1;
                else r.res = signed_quotient(c.a, c.b, 1'b1);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: present the next pending word; hold it while stalled.
    always @(posedge i_clk) begin
        t_cmd c;
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (cmd_queue.size() > 0 && !hold_off &&
                    $urandom_range(99) >= idle_pct) begin
                    c = cmd_queue.pop_front();
                    expected_results.push_back(alu_predict(c));
                    i_valid <= 1'b1;
                    i_opcode <= c.op;
                    i_operand_a <= c.a;
                    i_operand_b <= c.b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word, then pick the next stall.
    always @(posedge i_clk) begin
        t_alu_res e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no command outstanding: %h", o_result_word);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_word !== e.res) begin
                        $error("result_word: expected %h, got %h", e.res, o_result_word);
                        errors++;
                    end
                    if (o_carry_flag !== e.carry) begin
                        $error("carry_flag: expected %b, got %b", e.carry, o_carry_flag);
                        errors++;
                    end
                    if (o_overflow_flag !== e.ovf) begin
                        $error("overflow_flag: expected %b, got %b", e.ovf,
                               o_overflow_flag);
                        errors++;
                    end
                    if (o_error_flag !== e.err) begin
                        $error("error_flag: expected %b, got %b", e.err, o_error_flag);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [DataW-1:0] pick_operand();
        case ($urandom_range(7))
            0: return {16'h0, MinNeg16};
            1: return MinNeg32;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            4: return $urandom_range(3) == 0 ? 32'h1 : 32'h0000_FFFF;
            5: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(logic [OpW-1:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b);
        t_cmd c;
        c.op = op;
        c.a = a;
        c.b = b;
        cmd_queue.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || expected_results.size() > 0 || i_valid)
            @(posedge i_clk);
    endtask

    initial begin
        logic [OpW-1:0] op;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: every opcode, extremes, the special cases.
        add_cmd(OP_ADD16, 32'hFFFF_7FFF, 32'h0000_0001);
        add_cmd(OP_ADD16, 32'h0000_FFFF, 32'hFFFF_FFFF);
        add_cmd(OP_ADD32, 32'hFFFF_FFFF, 32'h0000_0001);
        add_cmd(OP_ADD32, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_cmd(OP_SUB16, 32'h0000_8000, 32'h0000_0001);
        add_cmd(OP_SUB16, 32'h0000_0000, 32'h0000_FFFF);
        add_cmd(OP_SUB32, 32'h0000_0000, 32'h0000_0001);
        add_cmd(OP_SUB32, MinNeg32, 32'h0000_0001);
        add_cmd(OP_NEG16, 32'h0000_8000, 32'h1234_5678);
        add_cmd(OP_NEG16, 32'hABCD_0001, 32'h0);
        add_cmd(OP_NEG32, MinNeg32, 32'h0);
        add_cmd(OP_NEG32, 32'h0000_0001, 32'hFFFF_FFFF);
        add_cmd(OP_MULLO, 32'h0000_FFFF, 32'h0000_FFFF);
        add_cmd(OP_MULLO, 32'h0000_8000, 32'h0000_0003);
        add_cmd(OP_MULHI, 32'h0000_FFFF, 32'h0000_FFFF);
        add_cmd(OP_MULHI, 32'h0000_0002, 32'hFFFF_8000);
        add_cmd(OP_DIV16, 32'h0000_0064, 32'hFFFF_0000);
        add_cmd(OP_DIV16, 32'h0000_8000, 32'h0000_FFFF);
        add_cmd(OP_DIV16, 32'h0000_FFF9, 32'h0000_0002);
        add_cmd(OP_DIV32, 32'h1234_5678, 32'h0);
        add_cmd(OP_DIV32, MinNeg32, 32'hFFFF_FFFF);
        add_cmd(OP_DIV32, 32'hFFFF_FFF9, 32'h0000_0002);
        add_cmd(4'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(4'd15, 32'h1, 32'h1);
        wait_drained();

        // Random phases: none, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 59 : (phase == 3) ? 19 : 0;
            stall_pct = (phase == 2) ? 59 : (phase == 3) ? 19 : 0;
            for (int n = 0; n < 500; n++) begin
                op = ($urandom_range(19) == 0) ? OpW'($urandom_range(15, 10))
                                               : OpW'($urandom_range(9));
                add_cmd(op, pick_operand(), pick_operand());
            end
            if (phase == 1) begin
                // Hold the sender until the pipe is empty, then resume.
                while (cmd_queue.size() > 250) @(posedge i_clk);
                hold_off = 1'b1;
                while (expected_results.size() > 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_drained();
            stall_pct = 0;
        end

        stim_done = 1'b1;
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_div_step.sv
sv/fixed_point_alu_16_32.sv
sim/testbench.sv
